>>> hdl/wmms_pkg.sv
package wmms_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int NUM_CH = 4;
    localparam int CH_W = $clog2(NUM_CH);
    localparam int DATA_W = 16;
    localparam int REC_W = NUM_CH * DATA_W;
    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = DATA_W + PTR_W;
    localparam int STEP_W = $clog2(SUM_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [DATA_W-1:0] cadence;
        logic [DATA_W-1:0] power;
        logic [DATA_W-1:0] pulse;
        logic [DATA_W-1:0] speed;
    } wmms_rec_t;

    typedef struct packed {
        logic      valid;
        wmms_rec_t rec;
    } wmms_queue_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_EMIT
    } wmms_state_t;

endpackage

>>> hdl/wmms_front.sv
module wmms_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [wmms_pkg::DATA_W-1:0]   s_speed_in,
    input  logic [wmms_pkg::DATA_W-1:0]   s_pulse_in,
    input  logic [wmms_pkg::DATA_W-1:0]   s_power_in,
    input  logic [wmms_pkg::DATA_W-1:0]   s_cadence_in,
    output wmms_pkg::wmms_queue_t         q_out,
    input  logic                          q_pop
);

    wmms_pkg::wmms_rec_t              entry_reg [wmms_pkg::QUEUE_DEPTH];
    logic [wmms_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [wmms_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [wmms_pkg::QFILL_W-1:0]     fill_reg, fill_next;
    wmms_pkg::wmms_rec_t              rec_in;
    logic                             push;
    logic                             pop;

    always_comb begin
        rec_in.speed = s_speed_in;
        rec_in.pulse = s_pulse_in;
        rec_in.power = s_power_in;
        rec_in.cadence = s_cadence_in;
    end

    assign s_ready = (fill_reg != wmms_pkg::QFILL_W'(wmms_pkg::QUEUE_DEPTH));
    assign push = s_valid && s_ready;
    assign pop = q_pop && (fill_reg != '0);

    assign q_out.valid = (fill_reg != '0);
    assign q_out.rec = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == wmms_pkg::QPTR_W'(wmms_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == wmms_pkg::QPTR_W'(wmms_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= rec_in;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= wmms_pkg::QFILL_W'(wmms_pkg::QUEUE_DEPTH))
        else $error("queue fill exceeds its depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (fill_reg != '0))
        else $error("queue popped while empty");

endmodule

>>> hdl/wmms_div.sv
module wmms_div (
    input  logic                          aclk,
    input  logic                          load,
    input  logic                          step,
    input  logic [wmms_pkg::SUM_W-1:0]    dividend,
    input  logic [wmms_pkg::CNT_W-1:0]    divisor,
    output logic [wmms_pkg::DATA_W-1:0]   quotient
);

    logic [wmms_pkg::CNT_W-1:0]  rem_reg;
    logic [wmms_pkg::SUM_W-1:0]  quo_reg;
    logic [wmms_pkg::CNT_W:0]    shifted;
    logic [wmms_pkg::CNT_W:0]    diff;
    logic                        fits;

    assign shifted = {rem_reg, quo_reg[wmms_pkg::SUM_W-1]};
    assign fits = (shifted >= {1'b0, divisor});
    assign diff = shifted - {1'b0, divisor};
    assign quotient = quo_reg[wmms_pkg::DATA_W-1:0];

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (step) begin
            rem_reg <= fits ? diff[wmms_pkg::CNT_W-1:0] : shifted[wmms_pkg::CNT_W-1:0];
            quo_reg <= {quo_reg[wmms_pkg::SUM_W-2:0], fits};
        end
    end

endmodule

>>> hdl/wmms_back.sv
module wmms_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wmms_pkg::wmms_queue_t         q_in,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wmms_pkg::CH_W-1:0]     m_channel,
    output logic [wmms_pkg::DATA_W-1:0]   m_low_value,
    output logic [wmms_pkg::DATA_W-1:0]   m_high_value,
    output logic [wmms_pkg::DATA_W-1:0]   m_mean_value,
    output logic                          m_last
);

    logic [wmms_pkg::REC_W-1:0]    mem [wmms_pkg::WINDOW_DEPTH];
    logic [wmms_pkg::REC_W-1:0]    rd_data_reg;
    logic                          rd_valid_reg;
    logic                          rd_en;
    logic [wmms_pkg::PTR_W-1:0]    rd_addr;
    logic                          mem_we;

    wmms_pkg::wmms_state_t         state_reg, state_next;
    logic [wmms_pkg::PTR_W-1:0]    ptr_reg, ptr_next;
    logic [wmms_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [wmms_pkg::CNT_W-1:0]    idx_reg, idx_next;
    logic [wmms_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [wmms_pkg::CH_W-1:0]     ch_reg, ch_next;
    logic                          scan_start;
    logic                          div_load;
    logic                          div_step;
    logic                          out_load;

    logic [wmms_pkg::DATA_W-1:0]   lane_val [wmms_pkg::NUM_CH];
    logic [wmms_pkg::DATA_W-1:0]   min_reg [wmms_pkg::NUM_CH];
    logic [wmms_pkg::DATA_W-1:0]   max_reg [wmms_pkg::NUM_CH];
    logic [wmms_pkg::SUM_W-1:0]    sum_reg [wmms_pkg::NUM_CH];
    logic [wmms_pkg::DATA_W-1:0]   quo [wmms_pkg::NUM_CH];

    logic                          m_valid_reg;
    logic [wmms_pkg::CH_W-1:0]     chan_out_reg;
    logic [wmms_pkg::DATA_W-1:0]   min_out_reg;
    logic [wmms_pkg::DATA_W-1:0]   max_out_reg;
    logic [wmms_pkg::DATA_W-1:0]   mean_out_reg;
    logic                          last_out_reg;

    assign rd_addr = idx_reg[wmms_pkg::PTR_W-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[ptr_reg] <= q_in.rec;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wmms_pkg::ST_IDLE;
            ptr_reg <= '0;
            count_reg <= '0;
            idx_reg <= '0;
            step_reg <= '0;
            ch_reg <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ptr_reg <= ptr_next;
            count_reg <= count_next;
            idx_reg <= idx_next;
            step_reg <= step_next;
            ch_reg <= ch_next;
            rd_valid_reg <= rd_en;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        ptr_next = ptr_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        step_next = step_reg;
        ch_next = ch_reg;
        q_pop = 1'b0;
        mem_we = 1'b0;
        rd_en = 1'b0;
        scan_start = 1'b0;
        div_load = 1'b0;
        div_step = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            wmms_pkg::ST_IDLE: begin
                if (q_in.valid) begin
                    q_pop = 1'b1;
                    mem_we = 1'b1;
                    ptr_next = (ptr_reg == wmms_pkg::PTR_W'(wmms_pkg::WINDOW_DEPTH - 1)) ?
                               '0 : ptr_reg + 1'b1;
                    if (count_reg != wmms_pkg::CNT_W'(wmms_pkg::WINDOW_DEPTH)) begin
                        count_next = count_reg + 1'b1;
                    end
                    idx_next = '0;
                    scan_start = 1'b1;
                    state_next = wmms_pkg::ST_SCAN;
                end
            end
            wmms_pkg::ST_SCAN: begin
                if (idx_reg != count_reg) begin
                    rd_en = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end else if (!rd_valid_reg) begin
                    div_load = 1'b1;
                    step_next = '0;
                    state_next = wmms_pkg::ST_DIV;
                end
            end
            wmms_pkg::ST_DIV: begin
                div_step = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == wmms_pkg::STEP_W'(wmms_pkg::SUM_W - 1)) begin
                    ch_next = '0;
                    state_next = wmms_pkg::ST_EMIT;
                end
            end
            wmms_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load = 1'b1;
                    ch_next = ch_reg + 1'b1;
                    if (ch_reg == wmms_pkg::CH_W'(wmms_pkg::NUM_CH - 1)) begin
                        state_next = wmms_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = wmms_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int c = 0; c < wmms_pkg::NUM_CH; c++) begin
            lane_val[c] = rd_data_reg[c*wmms_pkg::DATA_W +: wmms_pkg::DATA_W];
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < wmms_pkg::NUM_CH; c++) begin
            if (scan_start) begin
                min_reg[c] <= '1;
                max_reg[c] <= '0;
                sum_reg[c] <= '0;
            end else if (rd_valid_reg) begin
                if (lane_val[c] < min_reg[c]) begin
                    min_reg[c] <= lane_val[c];
                end
                if (lane_val[c] > max_reg[c]) begin
                    max_reg[c] <= lane_val[c];
                end
                sum_reg[c] <= sum_reg[c] + wmms_pkg::SUM_W'(lane_val[c]);
            end
        end
    end

    for (genvar g = 0; g < wmms_pkg::NUM_CH; g++) begin : g_div
        wmms_div u_div (
            .aclk     (aclk),
            .load     (div_load),
            .step     (div_step),
            .dividend (sum_reg[g]),
            .divisor  (count_reg),
            .quotient (quo[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            chan_out_reg <= ch_reg;
            min_out_reg <= min_reg[ch_reg];
            max_out_reg <= max_reg[ch_reg];
            mean_out_reg <= quo[ch_reg];
            last_out_reg <= (ch_reg == wmms_pkg::CH_W'(wmms_pkg::NUM_CH - 1));
        end
    end

    assign m_valid = m_valid_reg;
    assign m_channel = chan_out_reg;
    assign m_low_value = min_out_reg;
    assign m_high_value = max_out_reg;
    assign m_mean_value = mean_out_reg;
    assign m_last = last_out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= wmms_pkg::CNT_W'(wmms_pkg::WINDOW_DEPTH))
        else $error("entry count above window depth");

    a_busy_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != wmms_pkg::ST_IDLE) |-> (count_reg != '0))
        else $error("window empty while an item is in work");

    a_mean_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (min_out_reg <= mean_out_reg) && (mean_out_reg <= max_out_reg))
        else $error("mean outside the min and max of its channel");

endmodule

>>> hdl/window_min_max_mean_stats.sv
// Each accepted item is one record of four 16-bit readings (speed, heart rate, power, cadence).
// It is stored in a ring window of the last 32 records and then produces four result items,
// channel 0 to 3, with the minimum, maximum and floor mean over the records held; m_last
// marks the cadence result. A two-entry input queue accepts new items while the previous one
// is in work. The window is scanned through the single read port of its memory, one record a
// cycle, and the four means come from bit-serial dividers; back-pressure on the output stalls
// the emission of the four results.
module window_min_max_mean_stats (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [wmms_pkg::DATA_W-1:0]   s_speed_in,
    input  logic [wmms_pkg::DATA_W-1:0]   s_pulse_in,
    input  logic [wmms_pkg::DATA_W-1:0]   s_power_in,
    input  logic [wmms_pkg::DATA_W-1:0]   s_cadence_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wmms_pkg::CH_W-1:0]     m_channel,
    output logic [wmms_pkg::DATA_W-1:0]   m_low_value,
    output logic [wmms_pkg::DATA_W-1:0]   m_high_value,
    output logic [wmms_pkg::DATA_W-1:0]   m_mean_value,
    output logic                          m_last
);

    wmms_pkg::wmms_queue_t  queue;
    logic                   q_pop;

    wmms_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_speed_in      (s_speed_in),
        .s_pulse_in      (s_pulse_in),
        .s_power_in      (s_power_in),
        .s_cadence_in    (s_cadence_in),
        .q_out           (queue),
        .q_pop           (q_pop)
    );

    wmms_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_in         (queue),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_channel    (m_channel),
        .m_low_value  (m_low_value),
        .m_high_value (m_high_value),
        .m_mean_value (m_mean_value),
        .m_last       (m_last)
    );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TAIL_CYCLES = 200;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [wmms_pkg::CH_W-1:0]   channel;
        logic [wmms_pkg::DATA_W-1:0] low_value;
        logic [wmms_pkg::DATA_W-1:0] high_value;
        logic [wmms_pkg::DATA_W-1:0] mean_value;
        logic                        last;
    } chan_stats_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [wmms_pkg::DATA_W-1:0] s_speed_in = '0;
    logic [wmms_pkg::DATA_W-1:0] s_pulse_in = '0;
    logic [wmms_pkg::DATA_W-1:0] s_power_in = '0;
    logic [wmms_pkg::DATA_W-1:0] s_cadence_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [wmms_pkg::CH_W-1:0] m_channel;
    logic [wmms_pkg::DATA_W-1:0] m_low_value;
    logic [wmms_pkg::DATA_W-1:0] m_high_value;
    logic [wmms_pkg::DATA_W-1:0] m_mean_value;
    logic m_last;

    wmms_pkg::wmms_rec_t history [wmms_pkg::WINDOW_DEPTH];
    logic [wmms_pkg::PTR_W-1:0] history_wr = '0;
    int unsigned history_fill = 0;
    chan_stats_t pending_stats [$];
    chan_stats_t want;

    int mismatches = 0;
    int quiet_cycles = 0;
    int hold_request = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    window_min_max_mean_stats dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_speed_in      (s_speed_in),
        .s_pulse_in      (s_pulse_in),
        .s_power_in      (s_power_in),
        .s_cadence_in    (s_cadence_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_channel       (m_channel),
        .m_low_value     (m_low_value),
        .m_high_value    (m_high_value),
        .m_mean_value    (m_mean_value),
        .m_last          (m_last)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic wmms_pkg::wmms_rec_t make_rec(
            input logic [wmms_pkg::DATA_W-1:0] spd,
            input logic [wmms_pkg::DATA_W-1:0] pls,
            input logic [wmms_pkg::DATA_W-1:0] pwr,
            input logic [wmms_pkg::DATA_W-1:0] cad);
        wmms_pkg::wmms_rec_t r;
        r.speed = spd;
        r.pulse = pls;
        r.power = pwr;
        r.cadence = cad;
        return r;
    endfunction

    function automatic logic [wmms_pkg::DATA_W-1:0] pick_reading();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return wmms_pkg::DATA_W'($urandom_range(0, 255));
            3: return wmms_pkg::DATA_W'($urandom_range(16'hFF00, 16'hFFFF));
            default: return wmms_pkg::DATA_W'($urandom());
        endcase
    endfunction

    // Store the record in the ring and queue the four channel statistics.
    task automatic predict_window_stats(input wmms_pkg::wmms_rec_t rec);
        logic [wmms_pkg::REC_W-1:0] flat;
        logic [wmms_pkg::DATA_W-1:0] v;
        logic [wmms_pkg::DATA_W-1:0] lo;
        logic [wmms_pkg::DATA_W-1:0] hi;
        int unsigned sum;
        chan_stats_t st;
        history[history_wr] = rec;
        history_wr = (history_wr == wmms_pkg::PTR_W'(wmms_pkg::WINDOW_DEPTH - 1)) ?
                     '0 : history_wr + 1'b1;
        if (history_fill < wmms_pkg::WINDOW_DEPTH) begin
            history_fill++;
        end
        for (int ch = 0; ch < wmms_pkg::NUM_CH; ch++) begin
            lo = '1;
            hi = '0;
            sum = 0;
            for (int i = 0; i < history_fill; i++) begin
                flat = history[i];
                v = flat[ch*wmms_pkg::DATA_W +: wmms_pkg::DATA_W];
                if (v < lo) begin
                    lo = v;
                end
                if (v > hi) begin
                    hi = v;
                end
                sum += v;
            end
            st.channel = wmms_pkg::CH_W'(ch);
            st.low_value = lo;
            st.high_value = hi;
            st.mean_value = wmms_pkg::DATA_W'(sum / history_fill);
            st.last = (ch == wmms_pkg::NUM_CH - 1);
            pending_stats.push_back(st);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_window_stats(make_rec(s_speed_in, s_pulse_in, s_power_in,
                                          s_cadence_in));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_stats.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("unexpected result: channel %0d min %h max %h mean %h last %b",
                             m_channel, m_low_value, m_high_value, m_mean_value, m_last);
                end
                mismatches++;
            end else begin
                want = pending_stats.pop_front();
                if (m_channel !== want.channel || m_low_value !== want.low_value ||
                    m_high_value !== want.high_value || m_mean_value !== want.mean_value ||
                    m_last !== want.last) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("mismatch: channel %0d/%0d min %h/%h max %h/%h mean %h/%h last %b/%b",
                                 want.channel, m_channel, want.low_value, m_low_value,
                                 want.high_value, m_high_value, want.mean_value, m_mean_value,
                                 want.last, m_last);
                    end
                    mismatches++;
                end
            end
        end
    end

    // The receiver stalls in random bursts, or for a long stretch when a test asks.
    initial begin
        forever begin
            @(negedge aclk);
            if (stall_left == 0) begin
                if (hold_request != 0) begin
                    stall_left = hold_request;
                    hold_request = 0;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    stall_left = $urandom_range(1, 17);
                end
            end
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (!s_valid && pending_stats.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_stats.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_record(input wmms_pkg::wmms_rec_t rec, input bit allow_idle);
        int gap;
        gap = 0;
        @(negedge aclk);
        if (allow_idle && !calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_speed_in <= rec.speed;
        s_pulse_in <= rec.pulse;
        s_power_in <= rec.power;
        s_cadence_in <= rec.cadence;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_stats.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic test_extremes();
        send_record(make_rec(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
        send_record(make_rec(16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0);
        send_record(make_rec(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF), 1'b1);
        send_record(make_rec(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000), 1'b1);
        send_record(make_rec(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555), 1'b1);
        send_record(make_rec(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA), 1'b1);
        send_record(make_rec(16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE), 1'b1);
        send_record(make_rec(16'h8000, 16'h0001, 16'hFFFE, 16'h7FFF), 1'b1);
        send_record(make_rec(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0), 1'b1);
        send_record(make_rec(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1);
    endtask

    task automatic test_random_stream(input int count);
        for (int n = 0; n < count; n++) begin
            send_record(make_rec(pick_reading(), pick_reading(), pick_reading(),
                                 pick_reading()), 1'b1);
        end
    endtask

    // Readings near full scale over more than one window length overwrite the
    // oldest records and push every sum close to its largest value.
    task automatic test_full_window_high();
        for (int n = 0; n < wmms_pkg::WINDOW_DEPTH + 2; n++) begin
            send_record(make_rec(wmms_pkg::DATA_W'($urandom_range(16'hFFF0, 16'hFFFF)),
                                 wmms_pkg::DATA_W'($urandom_range(16'hFFF0, 16'hFFFF)),
                                 wmms_pkg::DATA_W'($urandom_range(16'hFFF0, 16'hFFFF)),
                                 wmms_pkg::DATA_W'($urandom_range(16'hFFF0, 16'hFFFF))),
                        1'b1);
        end
    endtask

    task automatic test_output_hold_off();
        hold_request = HOLD_OFF_CYCLES;
        for (int n = 0; n < 20; n++) begin
            send_record(make_rec(pick_reading(), pick_reading(), pick_reading(),
                                 pick_reading()), 1'b0);
        end
    endtask

    task automatic test_steady_tail();
        calm = 1'b1;
        for (int n = 0; n < 40; n++) begin
            send_record(make_rec(pick_reading(), pick_reading(), pick_reading(),
                                 pick_reading()), 1'b0);
        end
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        test_extremes();
        test_random_stream(70);
        test_full_window_high();
        test_output_hold_off();
        wait_drained();
        test_steady_tail();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_stats.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
